/* design/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, register map and conversion helpers for the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Measurement phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ECHO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TRIGGER_TICKS   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_SECONDS = 2'd1;
    localparam logic [1:0] REG_MAX_TICKS       = 2'd2;
    localparam logic [1:0] REG_NEAR_CM         = 2'd3;

    // Register reset values
    localparam logic [7:0]  TRIGGER_TICKS_RST   = 8'd3;
    localparam logic [7:0]  TIMEOUT_SECONDS_RST = 8'd2;
    localparam logic [15:0] MAX_TICKS_RST       = 16'd3556;
    localparam logic [7:0]  NEAR_CM_RST         = 8'd8;

    // Conversion constants
    localparam int unsigned TICKS_PER_CM = 14;
    localparam logic [7:0]  DIST_MAX     = 8'd255;
    localparam logic [7:0]  SECONDS_MAX  = 8'd255;
    // Smallest tick count whose distance no longer fits in 8 bits
    localparam logic [15:0] SAT_TICKS    = 16'(256 * TICKS_PER_CM);
    // ceil(2^16 / 14): exact floor quotient for counts below SAT_TICKS
    localparam logic [12:0] RECIP_14     = 13'd4682;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [7:0]  timeout_seconds;
        logic [15:0] max_ticks;
        logic [7:0]  near_cm;
    } cfg_t;

    // Convert a clamped tick count to centimeters, saturating at 255
    function automatic logic [7:0] ticks_to_cm(input logic [15:0] ticks);
        logic [24:0] prod;
        prod = ticks[11:0] * RECIP_14;
        if (ticks >= SAT_TICKS)
            return DIST_MAX;
        else
            return prod[23:16];
    endfunction

endpackage

/* design/uer_if.sv */
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channels for tick samples and ranging results.
// ----------------------------------------------------------------------------
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;
    logic second_tick;

    modport source (output valid, start_req, echo, second_tick, input ready);
    modport sink   (input valid, start_req, echo, second_tick, output ready);
endinterface

interface uer_out_if;
    logic       valid;
    logic       ready;
    logic       trigger;
    logic       done_res;
    logic [7:0] distance;
    logic [1:0] status;
    logic       near;

    modport source (output valid, trigger, done_res, distance, status, near,
                    input ready);
    modport sink   (input valid, trigger, done_res, distance, status, near,
                    output ready);
endinterface

/* design/uer_cfg_regs.sv */
// ----------------------------------------------------------------------------
// uer_cfg_regs
// APB-style register file holding the ranging configuration.
// ----------------------------------------------------------------------------
module uer_cfg_regs
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks   <= TRIGGER_TICKS_RST;
            cfg_reg.timeout_seconds <= TIMEOUT_SECONDS_RST;
            cfg_reg.max_ticks       <= MAX_TICKS_RST;
            cfg_reg.near_cm         <= NEAR_CM_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TRIGGER_TICKS:   cfg_reg.trigger_ticks   <= pwdata[7:0];
                REG_TIMEOUT_SECONDS: cfg_reg.timeout_seconds <= pwdata[7:0];
                REG_MAX_TICKS:       cfg_reg.max_ticks       <= pwdata[15:0];
                REG_NEAR_CM:         cfg_reg.near_cm         <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_TRIGGER_TICKS:   prdata = {24'd0, cfg_reg.trigger_ticks};
            REG_TIMEOUT_SECONDS: prdata = {24'd0, cfg_reg.timeout_seconds};
            REG_MAX_TICKS:       prdata = {16'd0, cfg_reg.max_ticks};
            REG_NEAR_CM:         prdata = {24'd0, cfg_reg.near_cm};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

/* design/ultrasonic_echo_ranger.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Ultrasonic ranging controller advanced by one tick sample per transfer.
// Result: registered into the output register on each input transfer.
// Throughput: one tick per cycle while the output register is free or draining;
// the phase register and counters are updated in a single pass, and sink backpressure stalls the input.
// Reset: async active low; idle phase, counters zero, registers at defaults.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    uer_in_if.sink       in_ch,
    uer_out_if.source    out_ch
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ALL_ONES = '1;

    cfg_t cfg;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] pulse_ticks_reg, pulse_ticks_next;
    logic [7:0]             seconds_waited_reg, seconds_waited_next;
    logic [7:0]             trigger_left_reg, trigger_left_next;

    logic       out_valid_reg;
    logic       trigger_reg, done_res_reg, near_reg;
    logic [7:0] distance_reg;
    logic [1:0] status_reg;

    logic       res_trigger, res_done, res_near;
    logic [7:0] res_distance;
    logic [1:0] res_status;

    logic             accept;
    logic [7:0]       trig_len;
    logic [7:0]       seconds_inc;
    logic             timeout_hit;
    logic             count_full;
    logic [CMP_W-1:0] pulse_ext, max_ext;
    logic [15:0]      clamped;
    logic [7:0]       meas_cm;

    uer_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Take a tick whenever the output register is free or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Shared conditions
    assign trig_len    = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
    assign seconds_inc = (seconds_waited_reg == SECONDS_MAX) ? SECONDS_MAX
                                                             : seconds_waited_reg + 8'd1;
    assign timeout_hit = seconds_inc >= cfg.timeout_seconds;
    assign count_full  = pulse_ticks_reg == COUNT_ALL_ONES;

    // Clamp the pulse width and convert to centimeters
    assign pulse_ext = CMP_W'(pulse_ticks_reg);
    assign max_ext   = CMP_W'(cfg.max_ticks);
    assign clamped   = (pulse_ext > max_ext) ? cfg.max_ticks : pulse_ext[15:0];
    assign meas_cm   = ticks_to_cm(clamped);

    // Next state
    always_comb
    begin
        phase_next          = phase_reg;
        pulse_ticks_next    = pulse_ticks_reg;
        seconds_waited_next = seconds_waited_reg;
        trigger_left_next   = trigger_left_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_ch.start_req)
                begin
                    seconds_waited_next = 8'd0;
                    pulse_ticks_next    = '0;
                    trigger_left_next   = trig_len - 8'd1;
                    phase_next          = (trig_len == 8'd1) ? PH_WAIT : PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                if (trigger_left_reg <= 8'd1)
                begin
                    trigger_left_next = 8'd0;
                    phase_next        = PH_WAIT;
                end
                else
                begin
                    trigger_left_next = trigger_left_reg - 8'd1;
                end
            end
            PH_WAIT:
            begin
                if (in_ch.echo)
                begin
                    pulse_ticks_next = '0;
                    phase_next       = PH_MEAS;
                end
                else if (in_ch.second_tick)
                begin
                    seconds_waited_next = seconds_inc;
                    if (timeout_hit)
                        phase_next = PH_IDLE;
                end
            end
            PH_MEAS:
            begin
                if (in_ch.echo)
                begin
                    if (count_full)
                    begin
                        pulse_ticks_next = '0;
                        phase_next       = PH_IDLE;
                    end
                    else
                    begin
                        pulse_ticks_next = pulse_ticks_reg + COUNT_WIDTH'(1);
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Result fields for this tick
    always_comb
    begin
        res_trigger  = 1'b0;
        res_done     = 1'b0;
        res_distance = 8'd0;
        res_status   = ST_OK;
        case (phase_reg)
            PH_IDLE:
                res_trigger = in_ch.start_req;
            PH_TRIG:
                res_trigger = 1'b1;
            PH_WAIT:
            begin
                if (!in_ch.echo && in_ch.second_tick && timeout_hit)
                begin
                    res_done   = 1'b1;
                    res_status = ST_NO_ECHO;
                end
            end
            PH_MEAS:
            begin
                if (!in_ch.echo)
                begin
                    res_done     = 1'b1;
                    res_distance = meas_cm;
                end
                else if (count_full)
                begin
                    res_done     = 1'b1;
                    res_distance = DIST_MAX;
                    res_status   = ST_OVERFLOW;
                end
            end
            default: ;
        endcase
        res_near = res_done && (res_distance <= cfg.near_cm);
    end

    // Advance state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            pulse_ticks_reg    <= '0;
            seconds_waited_reg <= 8'd0;
            trigger_left_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            pulse_ticks_reg    <= pulse_ticks_next;
            seconds_waited_reg <= seconds_waited_next;
            trigger_left_reg   <= trigger_left_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trigger_reg  <= res_trigger;
            done_res_reg <= res_done;
            distance_reg <= res_distance;
            status_reg   <= res_status;
            near_reg     <= res_near;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.trigger  = trigger_reg;
    assign out_ch.done_res = done_res_reg;
    assign out_ch.distance = distance_reg;
    assign out_ch.status   = status_reg;
    assign out_ch.near     = near_reg;

`ifndef SYNTHESIS
    // A reported result always returns the ranger to idle
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_done) |=> (phase_reg == PH_IDLE))
        else $error("result did not return to idle");

    // Overflow results carry the saturated distance
    a_ovf_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OVERFLOW) |-> (distance_reg == DIST_MAX))
        else $error("overflow without saturated distance");

    // Non-result ticks carry zeroed result fields
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_res_reg) |->
        (distance_reg == 8'd0 && status_reg == ST_OK && !near_reg))
        else $error("result fields set without done");

    // Trigger is driven only while starting or in the trigger phase
    a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_trigger) |-> (phase_reg == PH_IDLE || phase_reg == PH_TRIG))
        else $error("trigger driven outside trigger phase");
`endif

endmodule
